// ===== hdl/reap_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the
// rotated ellipse arc point generator. No dependencies.
package reap_pkg;

	localparam int MAX_POINTS_DEF  = 128;
	localparam int TRIG_STAGES_DEF = 16;

	localparam int FULL_TURN    = 5760;
	localparam int HALF_TURN    = 2880;
	localparam int QUARTER_TURN = 1440;
	localparam int STEP_ANGLE   = 48;

	localparam int XY_W = 34;
	localparam int Z_W  = 29;
	localparam int TRIG_W = 17;
	localparam int CNT_W = 11;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_RADIUS_X = 3'd2;
	localparam logic [2:0] REG_RADIUS_Y = 3'd3;
	localparam logic [2:0] REG_ROTATION = 3'd4;

	typedef struct packed {
		logic                   valid;
		logic signed [XY_W-1:0] px;
		logic signed [XY_W-1:0] py;
		logic signed [Z_W-1:0]  pz;
		logic                   pneg;
		logic signed [XY_W-1:0] rx;
		logic signed [XY_W-1:0] ry;
		logic signed [Z_W-1:0]  rz;
		logic                   rneg;
		logic                   in_range;
		logic                   last;
	} reap_cell_t;

	function automatic logic signed [Z_W-1:0] atan_deg20(input int idx);
		logic signed [Z_W-1:0] r;
		case (idx)
			0: r = 29'sd47185920;
			1: r = 29'sd27855475;
			2: r = 29'sd14718068;
			3: r = 29'sd7471121;
			4: r = 29'sd3750058;
			5: r = 29'sd1876857;
			6: r = 29'sd938658;
			7: r = 29'sd469357;
			8: r = 29'sd234682;
			9: r = 29'sd117342;
			10: r = 29'sd58671;
			11: r = 29'sd29335;
			12: r = 29'sd14668;
			13: r = 29'sd7334;
			14: r = 29'sd3667;
			15: r = 29'sd1833;
			16: r = 29'sd917;
			17: r = 29'sd458;
			18: r = 29'sd229;
			19: r = 29'sd115;
			20: r = 29'sd57;
			21: r = 29'sd29;
			22: r = 29'sd14;
			23: r = 29'sd7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/reap_cordic_cell.sv =====
// One CORDIC rotation cell: advances the point and rotation vectors by one
// micro-rotation. Depends on reap_pkg.
module reap_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  reap_pkg::reap_cell_t din,
	output reap_pkg::reap_cell_t out_q
);

	localparam logic signed [reap_pkg::Z_W-1:0] ATAN = reap_pkg::atan_deg20(IDX);

	reap_pkg::reap_cell_t nxt;

	always_comb begin
		nxt = din;
		if (din.pz >= 0) begin
			nxt.px = din.px - (din.py >>> IDX);
			nxt.py = din.py + (din.px >>> IDX);
			nxt.pz = din.pz - ATAN;
		end else begin
			nxt.px = din.px + (din.py >>> IDX);
			nxt.py = din.py - (din.px >>> IDX);
			nxt.pz = din.pz + ATAN;
		end
		if (din.rz >= 0) begin
			nxt.rx = din.rx - (din.ry >>> IDX);
			nxt.ry = din.ry + (din.rx >>> IDX);
			nxt.rz = din.rz - ATAN;
		end else begin
			nxt.rx = din.rx + (din.ry >>> IDX);
			nxt.ry = din.ry - (din.rx >>> IDX);
			nxt.rz = din.rz + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (en) begin
			out_q <= nxt;
		end
	end

endmodule

// ===== hdl/reap_mix.sv =====
// Rounds the CORDIC results, scales by the radii, rotates, adds the center
// and saturates. Holds the output register. Depends on reap_pkg.
module reap_mix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  reap_pkg::reap_cell_t din,
	input  logic signed [23:0]  center_x,
	input  logic signed [23:0]  center_y,
	input  logic [22:0]         radius_x,
	input  logic [22:0]         radius_y,
	output logic                valid,
	output logic [23:0]         point_x,
	output logic [23:0]         point_y,
	output logic                in_range,
	output logic                last_point
);

	localparam int TW = reap_pkg::TRIG_W;

	function automatic logic signed [TW-1:0] rnd(input logic signed [reap_pkg::XY_W-1:0] v,
		input logic neg);
		logic signed [reap_pkg::XY_W-1:0] t;
		logic signed [TW-1:0] c;
		t = (v + 34'sd16384) >>> 15;
		if (t > 34'sd32768) c = 17'sd32768;
		else if (t < -34'sd32768) c = -17'sd32768;
		else c = t[TW-1:0];
		return neg ? -c : c;
	endfunction

	logic [4:0] v_q;
	logic [1:0] fr_s1, fr_s2, fr_s3, fr_s4;
	logic signed [TW-1:0] c_s1, s_s1, cr_s1, sr_s1, cr_s2, sr_s2;
	logic signed [40:0] ex_s2, ey_s2;
	logic signed [57:0] xc_s3, ys_s3, xs_s3, yc_s3;
	logic signed [28:0] qx_s4, qy_s4;
	logic signed [58:0] sx, sy;
	logic signed [29:0] tx, ty;

	assign sx = 59'(xc_s3) - 59'(ys_s3) + 59'sd536870912;
	assign sy = 59'(xs_s3) + 59'(yc_s3) + 59'sd536870912;
	assign tx = 30'(qx_s4) + 30'(center_x);
	assign ty = 30'(qy_s4) + 30'(center_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], din.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= rnd(din.px, din.pneg);
			s_s1 <= rnd(din.py, din.pneg);
			cr_s1 <= rnd(din.rx, din.rneg);
			sr_s1 <= rnd(din.ry, din.rneg);
			fr_s1 <= {din.in_range, din.last};
			ex_s2 <= 41'(signed'({1'b0, radius_x})) * 41'(c_s1);
			ey_s2 <= 41'(signed'({1'b0, radius_y})) * 41'(s_s1);
			cr_s2 <= cr_s1;
			sr_s2 <= sr_s1;
			fr_s2 <= fr_s1;
			xc_s3 <= 58'(ex_s2) * 58'(cr_s2);
			ys_s3 <= 58'(ey_s2) * 58'(sr_s2);
			xs_s3 <= 58'(ex_s2) * 58'(sr_s2);
			yc_s3 <= 58'(ey_s2) * 58'(cr_s2);
			fr_s3 <= fr_s2;
			qx_s4 <= 29'(sx >>> 30);
			qy_s4 <= 29'(sy >>> 30);
			fr_s4 <= fr_s3;
			if (tx > 30'sd8388607) point_x <= 24'h7FFFFF;
			else if (tx < -30'sd8388608) point_x <= 24'h800000;
			else point_x <= tx[23:0];
			if (ty > 30'sd8388607) point_y <= 24'h7FFFFF;
			else if (ty < -30'sd8388608) point_y <= 24'h800000;
			else point_y <= ty[23:0];
			in_range <= fr_s4[1];
			last_point <= fr_s4[0];
		end
	end

	assign valid = v_q[4];

endmodule

// ===== hdl/rotated_ellipse_arc_points_core.sv =====
// Rotated ellipse arc point generator, top level. Depends on reap_pkg,
// reap_cordic_cell and reap_mix.
// Throughput: one point per cycle; the CORDIC cell chain and the multiplier
// stages are fully pipelined and advance together whenever the output can move.
// Reset: asynchronous, clears all valid bits and the configuration registers.
module rotated_ellipse_arc_points_core #(
	parameter int MAX_POINTS  = reap_pkg::MAX_POINTS_DEF,
	parameter int TRIG_STAGES = reap_pkg::TRIG_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // start_angle, end_angle, point_index, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // point_x, point_y
	output logic        m_tuser,  // in_range
	output logic        m_tlast   // last_point
);

	localparam int CNT_W_L = reap_pkg::CNT_W;

	logic signed [23:0] center_x_q, center_y_q;
	logic [22:0] radius_x_q, radius_y_q;
	logic [12:0] rotation_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_x_q <= '0;
			radius_y_q <= '0;
			rotation_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_addr)
				reap_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				reap_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				reap_pkg::REG_RADIUS_X: radius_x_q <= cfg_data[22:0];
				reap_pkg::REG_RADIUS_Y: radius_y_q <= cfg_data[22:0];
				reap_pkg::REG_ROTATION: rotation_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic out_valid;
	assign en = !out_valid || m_tready;
	assign s_tready = en;

	logic signed [13:0] start_a, end_a;
	logic [6:0] idx;
	logic signed [16:0] ang_raw, ang_off;
	logic [12:0] ang_red, rot_red;
	logic signed [14:0] span;
	logic [13:0] span_abs;
	logic [19:0] q_prod;
	logic [CNT_W_L-1:0] quo, cnt;

	assign start_a = s_tdata[13:0];
	assign end_a   = s_tdata[27:14];
	assign idx     = s_tdata[34:28];
	assign ang_raw = 17'(start_a) + signed'(17'(idx) * 17'd48);
	assign ang_off = ang_raw + 17'sd11520;

	always_comb begin
		if (ang_off >= 17'sd23040) ang_red = 13'(ang_off - 17'sd23040);
		else if (ang_off >= 17'sd17280) ang_red = 13'(ang_off - 17'sd17280);
		else if (ang_off >= 17'sd11520) ang_red = 13'(ang_off - 17'sd11520);
		else if (ang_off >= 17'sd5760) ang_red = 13'(ang_off - 17'sd5760);
		else ang_red = 13'(ang_off);
		if (rotation_q >= 13'(reap_pkg::FULL_TURN))
			rot_red = rotation_q - 13'(reap_pkg::FULL_TURN);
		else
			rot_red = rotation_q;
	end

	assign span = 15'(end_a) - 15'(start_a);
	assign span_abs = span[14] ? 14'(-span) : 14'(span);
	assign q_prod = 20'(span_abs[13:4]) * 20'd683;
	assign quo = CNT_W_L'(q_prod[19:11]);
	assign cnt = (quo > CNT_W_L'(MAX_POINTS)) ? CNT_W_L'(MAX_POINTS) : quo;

	logic v_s1, inr_s1, last_s1;
	logic [12:0] ang_s1, rot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang_red;
			rot_s1 <= rot_red;
			inr_s1 <= CNT_W_L'(idx) < cnt;
			last_s1 <= (cnt != '0) && (CNT_W_L'(idx) == cnt - CNT_W_L'(1));
		end
	end

	function automatic logic [14:0] fold(input logic [12:0] a);
		logic signed [13:0] f;
		logic neg;
		neg = 1'b0;
		if (a > 13'(reap_pkg::QUARTER_TURN) &&
			a < 13'(reap_pkg::FULL_TURN - reap_pkg::QUARTER_TURN)) begin
			f = 14'(a) - 14'(reap_pkg::HALF_TURN);
			neg = 1'b1;
		end else if (a >= 13'(reap_pkg::FULL_TURN - reap_pkg::QUARTER_TURN)) begin
			f = 14'(a) - 14'(reap_pkg::FULL_TURN);
		end else begin
			f = 14'(a);
		end
		return {neg, f};
	endfunction

	logic [14:0] pf, rf;
	reap_pkg::reap_cell_t chain [0:TRIG_STAGES];

	assign pf = fold(ang_s1);
	assign rf = fold(rot_s1);

	always_comb begin
		chain[0].valid = v_s1;
		chain[0].px = reap_pkg::CORDIC_GAIN;
		chain[0].py = '0;
		chain[0].pz = reap_pkg::Z_W'(signed'(pf[13:0])) <<< 16;
		chain[0].pneg = pf[14];
		chain[0].rx = reap_pkg::CORDIC_GAIN;
		chain[0].ry = '0;
		chain[0].rz = reap_pkg::Z_W'(signed'(rf[13:0])) <<< 16;
		chain[0].rneg = rf[14];
		chain[0].in_range = inr_s1;
		chain[0].last = last_s1;
	end

	for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
		reap_cordic_cell #(.IDX(g)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.din(chain[g]),
			.out_q(chain[g+1])
		);
	end

	logic [23:0] px, py;

	reap_mix u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.din(chain[TRIG_STAGES]),
		.center_x(center_x_q),
		.center_y(center_y_q),
		.radius_x(radius_x_q),
		.radius_y(radius_y_q),
		.valid(out_valid),
		.point_x(px),
		.point_y(py),
		.in_range(m_tuser),
		.last_point(m_tlast)
	);

	assign m_tvalid = out_valid;
	assign m_tdata = {py, px};

	a_last_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser) else $error("last point outside range");
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1) else $error("transfer lost at input stage");
	a_s1_angle: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (ang_s1 < 13'(reap_pkg::FULL_TURN)) && (rot_s1 < 13'(reap_pkg::FULL_TURN)))
		else $error("angle reduction out of range");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && last_s1 |-> inr_s1) else $error("flag mismatch at input stage");

endmodule
